// ===== hdl/bfifo_pkg.sv =====
package bfifo_pkg;

   localparam int DEPTH = 64;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QIDX_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      K_PUSH  = 2'd0,
      K_POP   = 2'd1,
      K_ALL   = 2'd2,
      K_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         data_byte;
      logic [CNT_W-1:0]   pop_count;
   } cmd_type;

   typedef struct packed {
      logic               full;
      logic               empty;
      logic [CNT_W-1:0]   free_space;
      logic [CNT_W-1:0]   occupancy;
      logic               run_last;
      logic               push_accepted;
      logic               data_valid;
      logic [7:0]         data_out;
   } res_type;

   typedef struct packed {
      logic [CNT_W-1:0]   occupancy;
      logic [CNT_W-1:0]   size;
   } stat_type;

   function automatic res_type status_res(logic [CNT_W-1:0] occ, logic [CNT_W-1:0] size);
      res_type r;
      r               = '0;
      r.run_last      = 1'b1;
      r.occupancy     = occ;
      r.free_space    = size - occ;
      r.empty         = (occ == '0);
      r.full          = (occ == size);
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] clamp_size(logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > CNT_W'(DEPTH)) begin
         r = CNT_W'(DEPTH);
      end
      return r;
   endfunction

   function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p, logic [CNT_W-1:0] size);
      logic [CNT_W-1:0] nxt;
      logic [PTR_W-1:0] r;
      nxt = CNT_W'(p) + CNT_W'(1);
      r   = (nxt >= size) ? '0 : nxt[PTR_W-1:0];
      return r;
   endfunction

endpackage

// ===== hdl/bfifo_ram.sv =====
module bfifo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bfifo_front.sv =====
module bfifo_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,
   input  logic [1:0]           req_tuser,
   output bfifo_pkg::cmd_type   hd_cmd,
   output logic                 hd_valid,
   input  logic                 hd_ready
);

   import bfifo_pkg::*;

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [QIDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   cmd_type           cmd;
   logic              push, pop;

   always_comb begin
      cmd.kind      = kind_type'(req_tuser);
      cmd.data_byte = req_tdata[7:0];
      cmd.pop_count = req_tdata[14:8];
   end

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign hd_valid   = (count_ff != '0);
   assign hd_cmd     = q_ff[rd_idx_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = hd_valid && hd_ready;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (push) begin
         wr_idx_in = (wr_idx_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_ff + QIDX_W'(1);
      end
      if (pop) begin
         rd_idx_in = (rd_idx_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_ff + QIDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_idx_ff] <= cmd;
      end
   end

endmodule

// ===== hdl/bfifo_back.sv =====
module bfifo_back (
   input  logic                 clock,
   input  logic                 reset,
   input  bfifo_pkg::cmd_type   hd_cmd,
   input  logic                 hd_valid,
   output logic                 hd_ready,
   input  logic                 csr_wr_en,
   input  logic [6:0]           csr_wr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bfifo_pkg::res_type   rsp_res,
   output bfifo_pkg::stat_type  stat
);

   import bfifo_pkg::*;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             out_valid_ff, out_valid_in;
   res_type          out_ff, out_in;
   logic             out_free;
   logic             ram_wr, ram_rd;
   logic [7:0]       ram_q;
   logic [CNT_W-1:0] run_len;
   res_type          res;

   assign out_free = !out_valid_ff || rsp_ready;
   assign hd_ready = (state_ff == ST_IDLE) && out_free;
   assign run_len  = ((hd_cmd.kind == K_ALL) || (hd_cmd.pop_count > occ_ff)) ?
                     occ_ff : hd_cmd.pop_count;

   bfifo_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wp_ff),
      .wr_data (hd_cmd.data_byte),
      .rd_en   (ram_rd),
      .rd_addr (rp_ff),
      .rd_data (ram_q)
   );

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      occ_in       = occ_ff;
      size_in      = size_ff;
      left_in      = left_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      ram_wr       = 1'b0;
      ram_rd       = 1'b0;
      res          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (hd_valid && out_free) begin
               unique case (hd_cmd.kind) inside
                  K_PUSH: begin
                     if (occ_ff == size_ff) begin
                        res = status_res(occ_ff, size_ff);
                     end else begin
                        ram_wr            = 1'b1;
                        wp_in             = advance(wp_ff, size_ff);
                        occ_in            = occ_ff + CNT_W'(1);
                        res               = status_res(occ_in, size_ff);
                        res.push_accepted = 1'b1;
                     end
                     out_valid_in = 1'b1;
                     out_in       = res;
                  end
                  K_POP, K_ALL: begin
                     if (run_len == '0) begin
                        out_valid_in = 1'b1;
                        out_in       = status_res(occ_ff, size_ff);
                     end else begin
                        left_in  = run_len;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     wp_in        = '0;
                     rp_in        = '0;
                     occ_in       = '0;
                     out_valid_in = 1'b1;
                     out_in       = status_res('0, size_ff);
                  end
               endcase
            end
         end
         ST_READ: begin
            ram_rd   = 1'b1;
            rp_in    = advance(rp_ff, size_ff);
            occ_in   = occ_ff - CNT_W'(1);
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (out_free) begin
               res            = status_res(occ_ff, size_ff);
               res.data_out   = ram_q;
               res.data_valid = 1'b1;
               res.run_last   = (left_ff == CNT_W'(1));
               out_valid_in   = 1'b1;
               out_in         = res;
               left_in        = left_ff - CNT_W'(1);
               state_in       = (left_ff == CNT_W'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_wr_en) begin
         size_in = clamp_size(csr_wr_data);
         wp_in   = '0;
         rp_in   = '0;
         occ_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         occ_ff       <= '0;
         size_ff      <= CNT_W'(DEPTH);
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         occ_ff       <= occ_in;
         size_ff      <= size_in;
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_res        = out_ff;
   assign stat.occupancy = occ_ff;
   assign stat.size      = size_ff;

endmodule

// ===== hdl/byte_ring_fifo_unit.sv =====
// Channel   Direction  Handshake              Contents
// req       in         req_tvalid/req_tready  tdata: byte, pop count; tuser: request kind
// rsp       out        rsp_tvalid/rsp_tready  tdata: byte, occupancy, free, flags; tlast
// csr       in         csr_wr_en              size in use, taken at once
// A push, a clear or a status request shows its result the cycle after it leaves the queue.
// Each popped byte passes through a registered ring store read, then the output register.
// A two-item request queue lets the input run ahead while a burst is being read out.
// Reset empties the ring; the store itself is not cleared.
// A stalled result holds in the output register and the back end waits behind it.
module byte_ring_fifo_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte[7:0], pop_count[14:8], zero
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // data_out, occupancy, free_space, empty_flag, full_flag
   output logic [1:0]  rsp_tuser,   // data_valid, push_accepted
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   import bfifo_pkg::*;

   cmd_type  hd_cmd;
   logic     hd_valid, hd_ready;
   res_type  res;
   stat_type stat;

   bfifo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .hd_cmd     (hd_cmd),
      .hd_valid   (hd_valid),
      .hd_ready   (hd_ready)
   );

   bfifo_back u_back (
      .clock       (clock),
      .reset       (reset),
      .hd_cmd      (hd_cmd),
      .hd_valid    (hd_valid),
      .hd_ready    (hd_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_res     (res),
      .stat        (stat)
   );

   assign rsp_tdata = {res.full, res.empty, res.free_space, res.occupancy, res.data_out};
   assign rsp_tuser = {res.push_accepted, res.data_valid};
   assign rsp_tlast = res.run_last;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      stat.occupancy <= stat.size)
      else $error("occupancy exceeds size in use");

   a_csr_empties: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> stat.occupancy == '0)
      else $error("size write did not empty the ring");

   a_pop_not_push: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.data_valid |-> !res.push_accepted)
      else $error("popped byte marked as accepted push");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (res.empty == (res.occupancy == '0)) && !(res.empty && res.full))
      else $error("inconsistent status flags");

endmodule
